>>> rtl/fom_pkg.sv
// Shared constants, types and helpers of the FIFO order matcher.
`default_nettype none
package fom_pkg;

  localparam int NUM_STOCKS  = 256;
  localparam int QUEUE_DEPTH = 32;

  localparam int STOCK_W = 8;
  localparam int QTY_W   = 32;
  localparam int ID_W    = 32;
  localparam int TOT_W   = 37;
  localparam int SA_W    = (NUM_STOCKS > 1) ? $clog2(NUM_STOCKS) : 1;
  localparam int HD_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int SLOT_W  = (NUM_STOCKS * QUEUE_DEPTH > 1) ?
                           $clog2(NUM_STOCKS * QUEUE_DEPTH) : 1;

  localparam logic KIND_RECORD  = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // One accepted order together with its range check.
  typedef struct packed {
    logic [STOCK_W-1:0] stock_id;
    logic               side;
    logic [QTY_W-1:0]   qty;
    logic [ID_W-1:0]    order_id;
    logic               bad_stock;
  } cmd_t;

  // One result item.
  typedef struct packed {
    logic               kind;
    logic [ID_W-1:0]    fill_order_id;
    logic [STOCK_W-1:0] fill_stock;
    logic               fill_side;
    logic [QTY_W-1:0]   fill_qty;
    logic [QTY_W-1:0]   rest_left;
    logic               rejected;
    logic               last;
  } res_t;

  // Per-stock book header.
  typedef struct packed {
    logic              side;
    logic [TOT_W-1:0]  total;
    logic [HD_W-1:0]   head;
    logic [CNT_W-1:0]  count;
  } book_t;

  // One resting order.
  typedef struct packed {
    logic [ID_W-1:0]  order_id;
    logic [QTY_W-1:0] orig_qty;
    logic [QTY_W-1:0] remaining;
  } entry_t;

  // Flat slot address of queue position pos of stock s.
  function automatic logic [SLOT_W-1:0] slot_of(input logic [SA_W-1:0] s,
                                                input logic [HD_W-1:0] pos);
    int unsigned a;
    a = int'(s) * QUEUE_DEPTH + int'(pos);
    return a[SLOT_W-1:0];
  endfunction

  // Next queue position, wrapping at the queue depth.
  function automatic logic [HD_W-1:0] pos_inc(input logic [HD_W-1:0] p);
    logic [HD_W-1:0] r;
    if (int'(p) == QUEUE_DEPTH - 1) r = '0;
    else r = p + HD_W'(1);
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/fom_if.sv
// Handshake interfaces for the order and result channels.
`default_nettype none
interface fom_in_if;
  logic                         valid;
  logic                         ready;
  logic [fom_pkg::STOCK_W-1:0]  stock_id;
  logic                         side;
  logic [fom_pkg::QTY_W-1:0]    qty;
  logic [fom_pkg::ID_W-1:0]     order_id;
  modport source (output valid, stock_id, side, qty, order_id, input ready);
  modport sink   (input valid, stock_id, side, qty, order_id, output ready);
endinterface

interface fom_out_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [fom_pkg::ID_W-1:0]     fill_order_id;
  logic [fom_pkg::STOCK_W-1:0]  fill_stock;
  logic                         fill_side;
  logic [fom_pkg::QTY_W-1:0]    fill_qty;
  logic [fom_pkg::QTY_W-1:0]    rest_left;
  logic                         rejected;
  logic                         last;
  modport source (output valid, kind, fill_order_id, fill_stock, fill_side,
                  fill_qty, rest_left, rejected, last, input ready);
  modport sink   (input valid, kind, fill_order_id, fill_stock, fill_side,
                  fill_qty, rest_left, rejected, last, output ready);
endinterface
`default_nettype wire

>>> rtl/fom_front.sv
// Front end: accepts orders, checks the stock range and queues them.
`default_nettype none
module fom_front (
  input  wire            clk,
  input  wire            rst_n,
  fom_in_if.sink         in_chan,
  output logic           cmd_valid,
  input  wire            cmd_ready,
  output fom_pkg::cmd_t  cmd
);

  fom_pkg::cmd_t q_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;
  fom_pkg::cmd_t in_cmd;

  always_comb begin
    in_cmd.stock_id  = in_chan.stock_id;
    in_cmd.side      = in_chan.side;
    in_cmd.qty       = in_chan.qty;
    in_cmd.order_id  = in_chan.order_id;
    in_cmd.bad_stock = (32'(in_chan.stock_id) >= 32'(fom_pkg::NUM_STOCKS));
  end

  assign in_chan.ready = (cnt_r != 2'd2);
  assign cmd_valid     = (cnt_r != 2'd0);
  assign cmd           = q_r[rp_r];
  assign push          = in_chan.valid & in_chan.ready;
  assign pop           = cmd_valid & cmd_ready;

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= in_cmd;
  end

endmodule
`default_nettype wire

>>> rtl/fom_engine.sv
// Back end: book lookup, queue walk and result register.
`default_nettype none
module fom_engine (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            cmd_valid,
  output logic           cmd_ready,
  input  fom_pkg::cmd_t  cmd,
  output logic           res_valid,
  input  wire            res_ready,
  output fom_pkg::res_t  res
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LOOK  = 4'd1;
  localparam logic [3:0] S_DEC   = 4'd2;
  localparam logic [3:0] S_WALK  = 4'd3;
  localparam logic [3:0] S_WRD   = 4'd4;
  localparam logic [3:0] S_DRAIN = 4'd5;
  localparam logic [3:0] S_DRD   = 4'd6;

  localparam int SA_W   = fom_pkg::SA_W;
  localparam int HD_W   = fom_pkg::HD_W;
  localparam int CNT_W  = fom_pkg::CNT_W;
  localparam int TOT_W  = fom_pkg::TOT_W;
  localparam int QTY_W  = fom_pkg::QTY_W;
  localparam int SLOT_W = fom_pkg::SLOT_W;

  // Book headers with reset-cleared valid bits, and the entry store.
  fom_pkg::book_t  bk_mem [fom_pkg::NUM_STOCKS];
  logic [fom_pkg::NUM_STOCKS-1:0] bk_vld_r;
  fom_pkg::book_t  bk_q_r;
  logic            bk_qv_r;
  fom_pkg::entry_t ent_mem [fom_pkg::NUM_STOCKS * fom_pkg::QUEUE_DEPTH];
  fom_pkg::entry_t ent_q_r;

  logic [3:0]        st_r, st_nxt;
  fom_pkg::cmd_t     cmd_r, cmd_nxt;
  logic              bs_r, bs_nxt;
  logic [TOT_W-1:0]  tot_r, tot_nxt;
  logic [HD_W-1:0]   hd_r, hd_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [QTY_W-1:0]  need_r, need_nxt, left_r, left_nxt;
  logic              ov_r, ov_nxt;
  fom_pkg::res_t     o_r, o_nxt;

  logic              ofree, ld;
  fom_pkg::res_t     ld_item;
  logic              bk_we;
  fom_pkg::book_t    bk_wd;
  logic              ent_we, ent_re;
  logic [SLOT_W-1:0] ent_wa, ent_ra;
  fom_pkg::entry_t   ent_wd;
  logic [SA_W-1:0]   sa, cmd_sa;
  logic [CNT_W:0]    tail_sum;
  logic [HD_W-1:0]   tail;

  assign sa     = cmd_r.stock_id[SA_W-1:0];
  assign cmd_sa = cmd.stock_id[SA_W-1:0];
  assign ofree  = !ov_r || res_ready;
  assign res_valid = ov_r;
  assign res       = o_r;

  always_comb begin
    tail_sum = {1'b0, CNT_W'(hd_r)} + {1'b0, cnt_r};
    if (32'(tail_sum) >= 32'(fom_pkg::QUEUE_DEPTH))
      tail_sum = tail_sum - (CNT_W+1)'(fom_pkg::QUEUE_DEPTH);
    tail = tail_sum[HD_W-1:0];
  end

  always_comb begin
    st_nxt   = st_r;
    cmd_nxt  = cmd_r;
    bs_nxt   = bs_r;
    tot_nxt  = tot_r;
    hd_nxt   = hd_r;
    cnt_nxt  = cnt_r;
    need_nxt = need_r;
    left_nxt = left_r;
    cmd_ready = 1'b0;
    ld       = 1'b0;
    ld_item  = '0;
    bk_we    = 1'b0;
    bk_wd    = '0;
    ent_we   = 1'b0;
    ent_wa   = '0;
    ent_wd   = '0;
    ent_re   = 1'b0;
    ent_ra   = fom_pkg::slot_of(sa, hd_r);

    // Summary defaults; the states below adjust them.
    ld_item.kind          = fom_pkg::KIND_SUMMARY;
    ld_item.fill_order_id = cmd_r.order_id;
    ld_item.fill_stock    = cmd_r.stock_id;
    ld_item.fill_side     = cmd_r.side;
    ld_item.fill_qty      = cmd_r.qty;
    ld_item.last          = 1'b1;

    case (st_r)
      S_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          cmd_nxt = cmd;
          st_nxt  = S_LOOK;
        end
      end
      S_LOOK: begin
        if (bk_qv_r) begin
          bs_nxt  = bk_q_r.side;
          tot_nxt = bk_q_r.total;
          hd_nxt  = bk_q_r.head;
          cnt_nxt = bk_q_r.count;
        end else begin
          bs_nxt  = 1'b0;
          tot_nxt = '0;
          hd_nxt  = '0;
          cnt_nxt = '0;
        end
        st_nxt = S_DEC;
      end
      S_DEC: begin
        if (cmd_r.bad_stock || (cmd_r.side == bs_r &&
            32'(cnt_r) >= 32'(fom_pkg::QUEUE_DEPTH))) begin
          ld_item.rejected = 1'b1;
          if (ofree) begin
            ld     = 1'b1;
            st_nxt = S_IDLE;
          end
        end else if (cmd_r.side == bs_r) begin
          ld_item.rest_left = cmd_r.qty;
          if (ofree) begin
            ld     = 1'b1;
            ent_we = 1'b1;
            ent_wa = fom_pkg::slot_of(sa, tail);
            ent_wd = '{cmd_r.order_id, cmd_r.qty, cmd_r.qty};
            bk_we  = 1'b1;
            bk_wd  = '{bs_r, tot_r + TOT_W'(cmd_r.qty), hd_r, cnt_r + CNT_W'(1)};
            st_nxt = S_IDLE;
          end
        end else if (tot_r >= TOT_W'(cmd_r.qty)) begin
          // The incoming order is completed first.
          ld_item.kind      = fom_pkg::KIND_RECORD;
          ld_item.last      = 1'b0;
          if (ofree) begin
            ld       = 1'b1;
            tot_nxt  = tot_r - TOT_W'(cmd_r.qty);
            need_nxt = cmd_r.qty;
            st_nxt   = S_WALK;
          end
        end else begin
          left_nxt = cmd_r.qty - tot_r[QTY_W-1:0];
          st_nxt   = S_DRAIN;
        end
      end
      S_WALK: begin
        if (need_r == '0 || cnt_r == '0) begin
          if (ofree) begin
            ld     = 1'b1;
            bk_we  = 1'b1;
            bk_wd  = '{bs_r, tot_r, hd_r, cnt_r};
            st_nxt = S_IDLE;
          end
        end else begin
          ent_re = 1'b1;
          st_nxt = S_WRD;
        end
      end
      S_WRD: begin
        ld_item.kind          = fom_pkg::KIND_RECORD;
        ld_item.fill_order_id = ent_q_r.order_id;
        ld_item.fill_side     = bs_r;
        ld_item.fill_qty      = ent_q_r.orig_qty;
        ld_item.last          = 1'b0;
        if (ent_q_r.remaining > need_r) begin
          ent_we   = 1'b1;
          ent_wa   = fom_pkg::slot_of(sa, hd_r);
          ent_wd   = '{ent_q_r.order_id, ent_q_r.orig_qty,
                       ent_q_r.remaining - need_r};
          need_nxt = '0;
          st_nxt   = S_WALK;
        end else if (ofree) begin
          ld       = 1'b1;
          need_nxt = need_r - ent_q_r.remaining;
          hd_nxt   = fom_pkg::pos_inc(hd_r);
          cnt_nxt  = cnt_r - CNT_W'(1);
          st_nxt   = S_WALK;
        end
      end
      S_DRAIN: begin
        if (cnt_r == '0) begin
          ld_item.rest_left = left_r;
          if (ofree) begin
            ld     = 1'b1;
            ent_we = 1'b1;
            ent_wa = fom_pkg::slot_of(sa, '0);
            ent_wd = '{cmd_r.order_id, cmd_r.qty, left_r};
            bk_we  = 1'b1;
            bk_wd  = '{cmd_r.side, TOT_W'(left_r), '0, CNT_W'(1)};
            st_nxt = S_IDLE;
          end
        end else begin
          ent_re = 1'b1;
          st_nxt = S_DRD;
        end
      end
      S_DRD: begin
        ld_item.kind          = fom_pkg::KIND_RECORD;
        ld_item.fill_order_id = ent_q_r.order_id;
        ld_item.fill_side     = bs_r;
        ld_item.fill_qty      = ent_q_r.orig_qty;
        ld_item.last          = 1'b0;
        if (ofree) begin
          ld      = 1'b1;
          hd_nxt  = fom_pkg::pos_inc(hd_r);
          cnt_nxt = cnt_r - CNT_W'(1);
          st_nxt  = S_DRAIN;
        end
      end
      default: st_nxt = S_IDLE;
    endcase

    ov_nxt = ld ? 1'b1 : (res_ready ? 1'b0 : ov_r);
    o_nxt  = ld ? ld_item : o_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_IDLE;
      ov_r     <= 1'b0;
      bk_vld_r <= '0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
      if (bk_we) bk_vld_r[sa] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    bs_r   <= bs_nxt;
    tot_r  <= tot_nxt;
    hd_r   <= hd_nxt;
    cnt_r  <= cnt_nxt;
    need_r <= need_nxt;
    left_r <= left_nxt;
    o_r    <= o_nxt;
  end

  // Book header memory: read when an order is taken.
  always_ff @(posedge clk) begin
    if (bk_we) bk_mem[sa] <= bk_wd;
    if (cmd_valid && cmd_ready) begin
      bk_q_r  <= bk_mem[cmd_sa];
      bk_qv_r <= bk_vld_r[cmd_sa];
    end
  end

  // Entry memory: one write and one registered read port.
  always_ff @(posedge clk) begin
    if (ent_we) ent_mem[ent_wa] <= ent_wd;
    if (ent_re) ent_q_r <= ent_mem[ent_ra];
  end

endmodule
`default_nettype wire

>>> rtl/fifo_order_matcher_top.sv
// Top level of the FIFO order matcher: front end, command queue, back end.
`default_nettype none
// Channel   Direction  Payload
// in_chan   in         stock_id, side, qty, order_id
// out_chan  out        kind, fill_order_id, fill_stock, fill_side, fill_qty,
//                      rest_left, rejected, last
//
// An append or a rejection takes the back end through taking the order,
// reading the book header and deciding. A match then walks the resting
// entries; each entry visited needs a read from the entry memory's
// registered read port before it is used. Reset is synchronous and active
// low; the book headers are cleared by per-stock valid bits at once, so no
// clearing pass is needed. A stalled result holds in the output register
// while the front end keeps taking up to two more orders.
module fifo_order_matcher_top (
  input  wire      clk,
  input  wire      rst_n,
  fom_in_if.sink   in_chan,
  fom_out_if.source out_chan
);

  logic          cmd_valid;
  logic          cmd_ready;
  fom_pkg::cmd_t cmd;
  fom_pkg::res_t res;

  // The front end queues orders so the back end can stall on its own.
  fom_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  // The back end walks the stock's queue and emits one item at a time.
  fom_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (out_chan.valid),
    .res_ready (out_chan.ready),
    .res       (res)
  );

  assign out_chan.kind          = res.kind;
  assign out_chan.fill_order_id = res.fill_order_id;
  assign out_chan.fill_stock    = res.fill_stock;
  assign out_chan.fill_side     = res.fill_side;
  assign out_chan.fill_qty      = res.fill_qty;
  assign out_chan.rest_left     = res.rest_left;
  assign out_chan.rejected      = res.rejected;
  assign out_chan.last          = res.last;

endmodule
`default_nettype wire

>>> tb/fifo_order_matcher_top_tb.sv
// Self-checking testbench for the FIFO order matcher top level.
`default_nettype none
module fifo_order_matcher_top_tb;

  localparam int NUM_STOCKS  = fom_pkg::NUM_STOCKS;
  localparam int QUEUE_DEPTH = fom_pkg::QUEUE_DEPTH;
  localparam int STOCK_W     = fom_pkg::STOCK_W;
  localparam int QTY_W       = fom_pkg::QTY_W;
  localparam int ID_W        = fom_pkg::ID_W;
  localparam int TOT_W       = fom_pkg::TOT_W;
  localparam logic KIND_RECORD  = fom_pkg::KIND_RECORD;
  localparam logic KIND_SUMMARY = fom_pkg::KIND_SUMMARY;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_ORDERS  = 80;

  logic clk;
  logic rst_n;

  fom_in_if  in_chan ();
  fom_out_if out_chan ();

  fifo_order_matcher_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan.sink),
    .out_chan (out_chan.source)
  );

  // Shadow copy of every book, indexed like the block's own storage.
  logic             shadow_side  [NUM_STOCKS];
  logic [TOT_W-1:0] shadow_total [NUM_STOCKS];
  int unsigned      shadow_head  [NUM_STOCKS];
  int unsigned      shadow_count [NUM_STOCKS];
  logic [ID_W-1:0]  slot_id      [NUM_STOCKS*QUEUE_DEPTH];
  logic [QTY_W-1:0] slot_orig    [NUM_STOCKS*QUEUE_DEPTH];
  logic [QTY_W-1:0] slot_left    [NUM_STOCKS*QUEUE_DEPTH];

  // Fills and summaries still owed by the block, oldest first.
  fom_pkg::res_t pending_fills[$];

  int  error_count;
  int  orders_sent;
  int  results_seen;
  int  quiet_cycles;
  bit  idle_enable;

  // One row of the directed table. A row with repeat_n above one is sent that
  // many times with the order id counting up. When check_summary is set, the
  // summary fields are typed in here instead of coming from the predictor.
  typedef struct {
    logic [STOCK_W-1:0] stock;
    logic               side;
    logic [QTY_W-1:0]   qty;
    logic [ID_W-1:0]    oid;
    int                 repeat_n;
    bit                 check_summary;
    logic [QTY_W-1:0]   rest;
    logic               rej;
  } order_row_t;

  always #4 clk = ~clk;

  // Queue one result item that the block must produce.
  function automatic void owe_fill(logic kind, logic [ID_W-1:0] oid,
                                   logic [STOCK_W-1:0] stock, logic side,
                                   logic [QTY_W-1:0] qty, logic [QTY_W-1:0] rest,
                                   logic rej);
    fom_pkg::res_t r;
    r.kind          = kind;
    r.fill_order_id = oid;
    r.fill_stock    = stock;
    r.fill_side     = side;
    r.fill_qty      = qty;
    r.rest_left     = rest;
    r.rejected      = rej;
    r.last          = (kind == KIND_SUMMARY);
    pending_fills   = {pending_fills, r};
  endfunction

  // Report and drop the oldest resting order of stock s.
  function automatic void retire_head(int unsigned s);
    int unsigned e;
    e = s * QUEUE_DEPTH + shadow_head[s];
    owe_fill(KIND_RECORD, slot_id[e], s[STOCK_W-1:0], shadow_side[s], slot_orig[e],
             '0, 1'b0);
    shadow_head[s] = (shadow_head[s] + 1) % QUEUE_DEPTH;
    shadow_count[s]--;
  endfunction

  // Apply one accepted order to the shadow books and queue what it yields.
  function automatic void match_order(logic [STOCK_W-1:0] stock, logic side,
                                      logic [QTY_W-1:0] qty, logic [ID_W-1:0] oid);
    int unsigned      s;
    int unsigned      e;
    logic [TOT_W-1:0] need;
    logic [QTY_W-1:0] rest;
    logic             rej;
    s    = stock;
    rest = '0;
    rej  = 1'b0;
    if (s >= NUM_STOCKS) begin
      rej = 1'b1;
    end else if (side == shadow_side[s]) begin
      if (shadow_count[s] >= QUEUE_DEPTH) begin
        rej = 1'b1;
      end else begin
        e = s * QUEUE_DEPTH + (shadow_head[s] + shadow_count[s]) % QUEUE_DEPTH;
        slot_id[e]   = oid;
        slot_orig[e] = qty;
        slot_left[e] = qty;
        shadow_count[s]++;
        shadow_total[s] += TOT_W'(qty);
        rest = qty;
      end
    end else if (shadow_total[s] >= TOT_W'(qty)) begin
      // Covered: the incoming order completes at once and eats into the queue.
      owe_fill(KIND_RECORD, oid, stock, side, qty, '0, 1'b0);
      shadow_total[s] -= TOT_W'(qty);
      need = TOT_W'(qty);
      while (need > 0 && shadow_count[s] > 0) begin
        e = s * QUEUE_DEPTH + shadow_head[s];
        if (TOT_W'(slot_left[e]) > need) begin
          slot_left[e] -= need[QTY_W-1:0];
          need = '0;
        end else begin
          need -= TOT_W'(slot_left[e]);
          retire_head(s);
        end
      end
    end else begin
      // Not covered: the whole book completes and the remainder flips it.
      rest = qty - shadow_total[s][QTY_W-1:0];
      while (shadow_count[s] > 0) retire_head(s);
      shadow_head[s]  = 0;
      e               = s * QUEUE_DEPTH;
      slot_id[e]      = oid;
      slot_orig[e]    = qty;
      slot_left[e]    = rest;
      shadow_count[s] = 1;
      shadow_total[s] = TOT_W'(rest);
      shadow_side[s]  = side;
    end
    owe_fill(KIND_SUMMARY, oid, stock, side, qty, rest, rej);
  endfunction

  // Present one order and hold it until the block takes it. The valid line is
  // only lowered for a random gap, never lowered and raised in one step.
  task automatic send_order(logic [STOCK_W-1:0] stock, logic side,
                            logic [QTY_W-1:0] qty, logic [ID_W-1:0] oid,
                            bit check_summary, logic [QTY_W-1:0] rest, logic rej);
    int gap;
    int last_idx;
    if (idle_enable && $urandom_range(99) < 10) begin
      gap = $urandom_range(4, 1);
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid    <= 1'b1;
    in_chan.stock_id <= stock;
    in_chan.side     <= side;
    in_chan.qty      <= qty;
    in_chan.order_id <= oid;
    do @(posedge clk); while (!in_chan.ready);
    match_order(stock, side, qty, oid);
    if (check_summary) begin
      last_idx = pending_fills.size() - 1;
      pending_fills[last_idx].rest_left = rest;
      pending_fills[last_idx].rejected  = rej;
    end
    orders_sent++;
  endtask

  // Random sizes: mostly small so books fill and drain, sometimes full range
  // so every bit of the quantity is exercised.
  function automatic logic [QTY_W-1:0] pick_qty();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 55) return $urandom_range(20);
    else if (p < 75) return $urandom_range(200);
    else if (p < 90) return $urandom();
    else return {QTY_W{1'b1}} - $urandom_range(3);
  endfunction

  // The result side drops ready at random while idling is enabled.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= idle_enable ? ($urandom_range(99) >= 10) : 1'b1;
    end
  end

  // Compare every accepted result with the oldest expected one.
  always @(posedge clk) begin
    fom_pkg::res_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      results_seen++;
      if (pending_fills.size() == 0) begin
        $error("unexpected result item, order id %0h", out_chan.fill_order_id);
        error_count++;
      end else begin
        want = pending_fills.pop_front();
        if (out_chan.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_chan.kind);
          error_count++;
        end
        if (out_chan.fill_order_id !== want.fill_order_id) begin
          $error("fill_order_id: expected %0h, got %0h", want.fill_order_id,
                 out_chan.fill_order_id);
          error_count++;
        end
        if (out_chan.fill_stock !== want.fill_stock) begin
          $error("fill_stock: expected %0d, got %0d", want.fill_stock, out_chan.fill_stock);
          error_count++;
        end
        if (out_chan.fill_side !== want.fill_side) begin
          $error("fill_side: expected %0d, got %0d", want.fill_side, out_chan.fill_side);
          error_count++;
        end
        if (out_chan.fill_qty !== want.fill_qty) begin
          $error("fill_qty: expected %0h, got %0h", want.fill_qty, out_chan.fill_qty);
          error_count++;
        end
        if (out_chan.rest_left !== want.rest_left) begin
          $error("rest_left: expected %0h, got %0h", want.rest_left, out_chan.rest_left);
          error_count++;
        end
        if (out_chan.rejected !== want.rejected) begin
          $error("rejected: expected %0d, got %0d", want.rejected, out_chan.rejected);
          error_count++;
        end
        if (out_chan.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_chan.last);
          error_count++;
        end
      end
    end
  end

  // Watchdog: the run is stuck when neither side moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", pending_fills.size());
      $display("fifo_order_matcher_top test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    order_row_t directed[$];
    order_row_t row;
    logic [STOCK_W-1:0] stock;

    clk              = 1'b0;
    rst_n            = 1'b0;
    in_chan.valid    = 1'b0;
    in_chan.stock_id = '0;
    in_chan.side     = 1'b0;
    in_chan.qty      = '0;
    in_chan.order_id = '0;
    error_count      = 0;
    orders_sent      = 0;
    results_seen     = 0;
    idle_enable      = 1'b1;
    for (int s = 0; s < NUM_STOCKS; s++) begin
      shadow_side[s]  = 1'b0;
      shadow_total[s] = '0;
      shadow_head[s]  = 0;
      shadow_count[s] = 0;
    end

    // Directed table. Every book starts empty on the buy side, so a buy is
    // appended and a sell against an empty book rests entirely.
    //          stock  side  qty            order id       rep  chk  rest           rej
    directed = '{
      '{8'd0,   1'b0, 32'd0,         32'h0000_0001, 1,  1,   32'd0,         1'b0},
      '{8'd0,   1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,  1,   32'hFFFF_FFFF, 1'b0},
      '{8'd0,   1'b1, 32'd0,         32'h0000_0002, 1,  1,   32'd0,         1'b0},
      '{8'd0,   1'b1, 32'd5,         32'h0000_0003, 1,  1,   32'd0,         1'b0},
      '{8'd0,   1'b1, 32'hFFFF_FFFF, 32'h0000_0004, 1,  1,   32'd5,         1'b0},
      '{8'd0,   1'b0, 32'd3,         32'h0000_0005, 1,  0,   32'd0,         1'b0},
      '{8'd255, 1'b1, 32'd10,        32'hA5A5_A5A5, 1,  1,   32'd10,        1'b0},
      '{8'd255, 1'b0, 32'd10,        32'h5A5A_5A5A, 1,  1,   32'd0,         1'b0},
      '{8'd255, 1'b0, 32'd7,         32'h0000_0006, 1,  1,   32'd7,         1'b0},
      // Fill one queue to the brim, then one more append is refused.
      '{8'd7,   1'b0, 32'd2,         32'h0000_0100, 32, 0,   32'd0,         1'b0},
      '{8'd7,   1'b0, 32'd9,         32'h0000_0200, 1,  1,   32'd0,         1'b1},
      // Partial match from the head, then a sweep that empties the queue and flips it.
      '{8'd7,   1'b1, 32'd3,         32'h0000_0300, 1,  1,   32'd0,         1'b0},
      '{8'd7,   1'b1, 32'hFFFF_FFFF, 32'h0000_0301, 1,  0,   32'd0,         1'b0},
      '{8'd7,   1'b0, 32'h8000_0000, 32'h0000_0302, 1,  0,   32'd0,         1'b0}
    };

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      row = directed[i];
      for (int n = 0; n < row.repeat_n; n++) begin
        send_order(row.stock, row.side, row.qty, row.oid + n, row.check_summary,
                   row.rest, row.rej);
      end
    end

    // Random orders. Most hit a handful of books so queues grow deep and
    // matches walk several entries; a few land anywhere.
    for (int i = 0; i < RANDOM_ORDERS; i++) begin
      // A run of back-to-back traffic with no gaps on either side.
      idle_enable = !(i >= 20 && i < 50);
      // Hold off until the block has drained completely once.
      if (i == 60) begin
        in_chan.valid <= 1'b0;
        @(posedge clk);
        while (pending_fills.size() != 0) @(posedge clk);
      end
      stock = ($urandom_range(99) < 85) ? 8'($urandom_range(3)) : 8'($urandom_range(255));
      send_order(stock, 1'($urandom_range(1)), pick_qty(), $urandom(), 1'b0, '0, 1'b0);
    end
    in_chan.valid <= 1'b0;
    idle_enable = 1'b1;

    while (pending_fills.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);

    $display("Sent %0d orders (appends, covered and uncovered matches, a full queue);",
             orders_sent);
    $display("checked %0d result items field by field, %0d mismatches.", results_seen,
             error_count);
    if (error_count == 0) begin
      $display("fifo_order_matcher_top test passed");
    end else begin
      $display("fifo_order_matcher_top test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
